// ----- src/vbpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_pkg
// shared types and constants of the vertex batcher with planar texgen
// ----------------------------------------------------------------------------
package vbpt_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_STARTED  = 2'd3
    } status_t;

    // polygon tracking mode of the front end
    typedef enum logic [1:0] {
        MODE_BETWEEN  = 2'd0,
        MODE_STORING  = 2'd1,
        MODE_SKIPPING = 2'd2,
        MODE_FULL     = 2'd3
    } mode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_U_AXIS_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_U_AXIS_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_U_AXIS_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V_AXIS_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_AXIS_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_AXIS_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_U_OFFSET = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET = 4'd7;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] u_axis_x;
        logic [31:0] u_axis_y;
        logic [31:0] u_axis_z;
        logic [31:0] v_axis_x;
        logic [31:0] v_axis_y;
        logic [31:0] v_axis_z;
        logic [31:0] u_offset;
        logic [31:0] v_offset;
    } cfg_t;

    // one classified request, as handed from front to back
    typedef struct packed {
        status_t     status;
        logic [11:0] vertex_index;
        logic [10:0] poly_index;
        logic [11:0] poly_first_vertex;
        logic [12:0] poly_count_out;
        logic        first_of_poly;
        logic [12:0] total_vertices;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } rec_t;

endpackage

`default_nettype wire

// ----- src/vbpt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_front
// classifies each request against the batch state and builds its record
// ----------------------------------------------------------------------------
module vbpt_front
    import vbpt_pkg::*;
#(
    parameter int VERTEX_CAP = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        command,
    input  wire logic [15:0] poly_points,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    output rec_t             rec
);

    localparam int CW      = $clog2(VERTEX_CAP + 1);
    localparam int PolyCap = VERTEX_CAP / 3;
    localparam int PW      = $clog2(PolyCap + 1);
    localparam logic [31:0] Cap32     = 32'(VERTEX_CAP);
    localparam logic [31:0] PolyCap32 = 32'(PolyCap);

    mode_t          mode_reg, mode_next;
    logic [CW-1:0]  vtotal_reg, vtotal_next;
    logic [PW-1:0]  ptotal_reg, ptotal_next;
    logic [15:0]    left_reg, left_next;
    logic [CW-1:0]  start_reg, start_next;
    logic [CW-1:0]  slot_reg, slot_next;

    logic           n_zero;
    logic           n_over;
    logic           no_fit;
    logic [CW-1:0]  n_cw;
    logic [15:0]    left_dec;

    assign n_zero   = (poly_points == 16'd0);
    assign n_over   = ({16'd0, poly_points} > Cap32);
    assign no_fit   = (32'(ptotal_reg) >= PolyCap32) ||
                      ({16'd0, poly_points} > (Cap32 - 32'(vtotal_reg)));
    // only used once the count is known to be within capacity
    assign n_cw     = CW'(poly_points);
    assign left_dec = (left_reg == 16'd0) ? 16'd0 : left_reg - 16'd1;

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        vtotal_next = vtotal_reg;
        ptotal_next = ptotal_reg;
        left_next   = left_reg;
        start_next  = start_reg;
        slot_next   = slot_reg;
        if (accept)
        begin
            if (command)
            begin
                mode_next   = MODE_BETWEEN;
                vtotal_next = '0;
                ptotal_next = '0;
                left_next   = '0;
                start_next  = '0;
                slot_next   = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_FULL:
                    begin
                    end
                    MODE_SKIPPING:
                    begin
                        left_next = left_dec;
                        if (left_dec == 16'd0)
                            mode_next = MODE_BETWEEN;
                    end
                    MODE_STORING:
                    begin
                        slot_next = slot_reg + CW'(1);
                        left_next = left_reg - 16'd1;
                        if (left_reg == 16'd1)
                            mode_next = MODE_BETWEEN;
                    end
                    MODE_BETWEEN:
                    begin
                        if (n_zero)
                        begin
                        end
                        else if (n_over)
                        begin
                            left_next = poly_points - 16'd1;
                            mode_next = (poly_points == 16'd1) ? MODE_BETWEEN
                                                               : MODE_SKIPPING;
                        end
                        else if (no_fit)
                        begin
                            left_next = '0;
                            mode_next = MODE_FULL;
                        end
                        else
                        begin
                            start_next  = vtotal_reg;
                            slot_next   = vtotal_reg + CW'(1);
                            vtotal_next = vtotal_reg + n_cw;
                            ptotal_next = ptotal_reg + PW'(1);
                            left_next   = poly_points - 16'd1;
                            mode_next   = (poly_points == 16'd1) ? MODE_BETWEEN
                                                                 : MODE_STORING;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // record for the current request
    always_comb
    begin
        logic          first;
        logic          stored;
        logic [CW-1:0] slot_cw;
        logic [CW-1:0] pfirst_cw;
        logic [CW-1:0] cnt_cw;
        logic [PW-1:0] pidx_pw;
        logic [31:0]   slot32;
        logic [31:0]   pfirst32;
        logic [31:0]   cnt32;
        logic [31:0]   pidx32;
        logic [31:0]   total32;

        first = 1'b0;
        stored = 1'b0;
        rec = '0;
        if (command)
            rec.status = ST_STARTED;
        else
        begin
            case (mode_reg)
                MODE_FULL:     rec.status = ST_REJECTED;
                MODE_SKIPPING: rec.status = ST_SKIPPED;
                MODE_STORING:
                begin
                    rec.status = ST_STORED;
                    stored = 1'b1;
                end
                MODE_BETWEEN:
                begin
                    if (n_zero || n_over)
                        rec.status = ST_SKIPPED;
                    else if (no_fit)
                        rec.status = ST_REJECTED;
                    else
                    begin
                        rec.status = ST_STORED;
                        stored = 1'b1;
                        first = 1'b1;
                    end
                end
                default:       rec.status = ST_REJECTED;
            endcase
        end

        slot_cw   = first ? vtotal_reg : slot_reg;
        pfirst_cw = first ? vtotal_reg : start_reg;
        cnt_cw    = first ? n_cw : (vtotal_reg - start_reg);
        pidx_pw   = first ? ptotal_reg : (ptotal_reg - PW'(1));
        slot32    = 32'(slot_cw);
        pfirst32  = 32'(pfirst_cw);
        cnt32     = 32'(cnt_cw);
        pidx32    = 32'(pidx_pw);
        total32   = 32'(vtotal_next);

        if (stored)
        begin
            rec.vertex_index      = slot32[11:0];
            rec.poly_index        = pidx32[10:0];
            rec.poly_first_vertex = pfirst32[11:0];
            rec.poly_count_out    = cnt32[12:0];
            rec.first_of_poly     = first;
            rec.pos_x             = pos_x;
            rec.pos_y             = pos_y;
            rec.pos_z             = pos_z;
        end
        rec.total_vertices = total32[12:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BETWEEN;
            vtotal_reg <= '0;
            ptotal_reg <= '0;
            left_reg   <= '0;
            start_reg  <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            vtotal_reg <= vtotal_next;
            ptotal_reg <= ptotal_next;
            left_reg   <= left_next;
            start_reg  <= start_next;
            slot_reg   <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/vbpt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_queue
// short record queue that decouples the front end from the texgen back end
// ----------------------------------------------------------------------------
module vbpt_queue
    import vbpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire rec_t push_data,
    output logic      full,
    input  wire logic pop,
    output rec_t      pop_data,
    output logic      empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    rec_t           mem [QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == NW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/vbpt_texgen.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vbpt_texgen
// three-stage texgen pipeline: products, sums, floor/offset/saturate
// ----------------------------------------------------------------------------
module vbpt_texgen
    import vbpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    input  wire rec_t  in_rec,
    output logic       in_ready,
    output logic       res_valid,
    output rec_t       res_rec,
    output logic [31:0] res_u,
    output logic [31:0] res_v,
    input  wire logic  res_take
);

    localparam logic signed [66:0] SatMax = 67'sd2147483647;
    localparam logic signed [66:0] SatMin = -67'sd2147483648;

    logic adv;

    logic               v1_reg;
    rec_t               rec1_reg;
    logic signed [63:0] pu_reg [3];
    logic signed [63:0] pv_reg [3];

    logic               v2_reg;
    rec_t               rec2_reg;
    logic signed [65:0] su_reg, sv_reg;

    logic               v3_reg;
    rec_t               rec3_reg;
    logic [31:0]        u3_reg, v3d_reg;

    logic signed [63:0] pu_next [3];
    logic signed [63:0] pv_next [3];
    logic signed [65:0] su_next, sv_next;
    logic [31:0]        u_next, v_next;

    // whole pipeline moves when the output slot is free or being taken
    assign adv      = !v3_reg || res_take;
    assign in_ready = adv;

    always_comb
    begin
        pu_next[0] = 64'($signed(cfg.u_axis_x)) * 64'($signed(in_rec.pos_x));
        pu_next[1] = 64'($signed(cfg.u_axis_y)) * 64'($signed(in_rec.pos_y));
        pu_next[2] = 64'($signed(cfg.u_axis_z)) * 64'($signed(in_rec.pos_z));
        pv_next[0] = 64'($signed(cfg.v_axis_x)) * 64'($signed(in_rec.pos_x));
        pv_next[1] = 64'($signed(cfg.v_axis_y)) * 64'($signed(in_rec.pos_y));
        pv_next[2] = 64'($signed(cfg.v_axis_z)) * 64'($signed(in_rec.pos_z));
        su_next = 66'(pu_reg[0]) + 66'(pu_reg[1]) + 66'(pu_reg[2]);
        sv_next = 66'(pv_reg[0]) + 66'(pv_reg[1]) + 66'(pv_reg[2]);
    end

    // floor to q16.16, remove offset, clamp; non-stored results carry zero
    always_comb
    begin
        logic signed [66:0] ru;
        logic signed [66:0] rv;

        ru = 67'(su_reg >>> 16) - 67'($signed(cfg.u_offset));
        rv = 67'(sv_reg >>> 16) - 67'($signed(cfg.v_offset));
        if (ru > SatMax)
            ru = SatMax;
        else if (ru < SatMin)
            ru = SatMin;
        if (rv > SatMax)
            rv = SatMax;
        else if (rv < SatMin)
            rv = SatMin;
        u_next = (rec2_reg.status == ST_STORED) ? 32'(ru) : 32'd0;
        v_next = (rec2_reg.status == ST_STORED) ? 32'(rv) : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec1_reg <= in_rec;
            for (int i = 0; i < 3; i++)
            begin
                pu_reg[i] <= pu_next[i];
                pv_reg[i] <= pv_next[i];
            end
            rec2_reg <= rec1_reg;
            su_reg   <= su_next;
            sv_reg   <= sv_next;
            rec3_reg <= rec2_reg;
            u3_reg   <= u_next;
            v3d_reg  <= v_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res_valid = v3_reg;
    assign res_rec   = rec3_reg;
    assign res_u     = u3_reg;
    assign res_v     = v3d_reg;

endmodule

`default_nettype wire

// ----- src/vertex_batcher_planar_texgen_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_batcher_planar_texgen_core
// packs polygon vertices into a batch and generates planar texture coords
// ----------------------------------------------------------------------------
// usage
// - input queue side: a request (vertex or start-batch command) is taken at a
//   clock edge with push high and full low
// - result queue side: the oldest result sits on the result ports while
//   empty is low and is taken at an edge with pop high
// - config channel: cfg_valid/cfg_ready write cfg_data to register cfg_index;
//   cfg_ready is always high, indexes above v_offset are ignored; write only
//   while no request is in flight
// - every request gives exactly one result, in order
// - path: a request taken passes the queue, the product stage, the sum stage
//   and the saturate/output stage before it shows on the result ports
// - throughput: one request per cycle while full is low, set by the classify
//   step in the front end and the fully pipelined multiply/sum stages
// - when pop is held low the back pipeline freezes; the 4-entry queue between
//   front and back keeps taking requests until it fills, then full rises
// - reset: batch empty, between polygons, config registers zero, all queues
//   and pipeline stages empty
// ----------------------------------------------------------------------------
module vertex_batcher_planar_texgen_core
    import vbpt_pkg::*;
#(
    parameter int VERTEX_CAP = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request side
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 command,
    input  wire logic [15:0]          poly_points,
    input  wire logic [31:0]          pos_x,
    input  wire logic [31:0]          pos_y,
    input  wire logic [31:0]          pos_z,
    // result side
    output logic                      empty,
    input  wire logic                 pop,
    output logic [1:0]                status,
    output logic [11:0]               vertex_index,
    output logic [10:0]               poly_index,
    output logic [11:0]               poly_first_vertex,
    output logic [12:0]               poly_count_out,
    output logic                      first_of_poly,
    output logic [31:0]               tex_u,
    output logic [31:0]               tex_v,
    output logic [31:0]               out_x,
    output logic [31:0]               out_y,
    output logic [31:0]               out_z,
    output logic [12:0]               total_vertices,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic accept;
    rec_t front_rec;
    rec_t q_rec;
    logic q_empty;
    logic q_full;
    logic back_ready;
    logic res_valid;
    rec_t res_rec;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_U_AXIS_X: cfg_next.u_axis_x = cfg_data;
                CFG_U_AXIS_Y: cfg_next.u_axis_y = cfg_data;
                CFG_U_AXIS_Z: cfg_next.u_axis_z = cfg_data;
                CFG_V_AXIS_X: cfg_next.v_axis_x = cfg_data;
                CFG_V_AXIS_Y: cfg_next.v_axis_y = cfg_data;
                CFG_V_AXIS_Z: cfg_next.v_axis_z = cfg_data;
                CFG_U_OFFSET: cfg_next.u_offset = cfg_data;
                CFG_V_OFFSET: cfg_next.v_offset = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // front end: classify and update batch state
    assign full   = q_full;
    assign accept = push && !q_full;

    vbpt_front #(
        .VERTEX_CAP (VERTEX_CAP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .poly_points (poly_points),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .rec         (front_rec)
    );

    // decoupling queue
    vbpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_rec),
        .full      (q_full),
        .pop       (back_ready),
        .pop_data  (q_rec),
        .empty     (q_empty)
    );

    // back end: texture coordinate pipeline with output register
    vbpt_texgen u_texgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (!q_empty),
        .in_rec    (q_rec),
        .in_ready  (back_ready),
        .res_valid (res_valid),
        .res_rec   (res_rec),
        .res_u     (tex_u),
        .res_v     (tex_v),
        .res_take  (pop)
    );

    assign empty             = !res_valid;
    assign status            = res_rec.status;
    assign vertex_index      = res_rec.vertex_index;
    assign poly_index        = res_rec.poly_index;
    assign poly_first_vertex = res_rec.poly_first_vertex;
    assign poly_count_out    = res_rec.poly_count_out;
    assign first_of_poly     = res_rec.first_of_poly;
    assign out_x             = res_rec.pos_x;
    assign out_y             = res_rec.pos_y;
    assign out_z             = res_rec.pos_z;
    assign total_vertices    = res_rec.total_vertices;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertex batcher with planar texgen: drives
// vertex and start-batch requests through the push/full side, predicts every
// result (batch bookkeeping plus saturated Q16.16 texture coords) and checks
// it field by field as it is popped, under random gaps on both sides
// ----------------------------------------------------------------------------
module tb_top;
    import vbpt_pkg::*;

    localparam int          VCAP         = 4096;
    localparam int          MAX_POLYS    = VCAP / 3;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1_500_000;
    localparam longint      SAT_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      SAT_MIN      = -64'sh0000_0000_8000_0000;
    // an index past the last mapping register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

    // one vertex or start-batch request as it goes into the block
    typedef struct packed {
        logic        command;
        logic [15:0] points;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vtx_req_t;

    // one result as it comes out of the block
    typedef struct packed {
        status_t     status;
        logic [11:0] vertex_index;
        logic [10:0] poly_index;
        logic [11:0] poly_first_vertex;
        logic [12:0] poly_count_out;
        logic        first_of_poly;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [12:0] total_vertices;
    } batch_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 command;
    logic [15:0]          poly_points;
    logic [31:0]          pos_x;
    logic [31:0]          pos_y;
    logic [31:0]          pos_z;
    logic                 empty;
    logic                 pop;
    logic [1:0]           status;
    logic [11:0]          vertex_index;
    logic [10:0]          poly_index;
    logic [11:0]          poly_first_vertex;
    logic [12:0]          poly_count_out;
    logic                 first_of_poly;
    logic [31:0]          tex_u;
    logic [31:0]          tex_v;
    logic [31:0]          out_x;
    logic [31:0]          out_y;
    logic [31:0]          out_z;
    logic [12:0]          total_vertices;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    vertex_batcher_planar_texgen_core #(
        .VERTEX_CAP(VCAP)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .command          (command),
        .poly_points      (poly_points),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .vertex_index     (vertex_index),
        .poly_index       (poly_index),
        .poly_first_vertex(poly_first_vertex),
        .poly_count_out   (poly_count_out),
        .first_of_poly    (first_of_poly),
        .tex_u            (tex_u),
        .tex_v            (tex_v),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .total_vertices   (total_vertices),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench-side copy of the mapping registers and the batch bookkeeping
    // ------------------------------------------------------------------------
    logic [31:0] map_regs [8] = '{default: '0};

    int unsigned batch_vtx_total  = 0;
    int unsigned batch_poly_total = 0;
    int unsigned poly_pts_left    = 0;
    mode_t       poly_mode        = MODE_BETWEEN;
    int unsigned poly_first_slot  = 0;
    int unsigned write_slot       = 0;

    // results still owed by the block, oldest first
    batch_res_t  pending_results [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // idling controls shared by the sender, the receiver and the tests
    bit          tx_idle_en     = 1'b0;
    bit          rx_idle_en     = 1'b0;
    int          rx_hold_cycles = 0;

    // point count of the polygon the random stream is working on
    logic [15:0] cur_poly_n     = 16'd1;

    // ------------------------------------------------------------------------
    // planar coord: exact Q32.32 products, floor of the sum to Q16.16, exact
    // offset subtract, then clamp to the signed 32-bit range
    // ------------------------------------------------------------------------
    function automatic logic [31:0] planar_coord(input logic [31:0] ax, ay, az, off,
                                                 input logic [31:0] px, py, pz);
        longint             p0;
        longint             p1;
        longint             p2;
        logic signed [67:0] acc;
        longint             r;
        p0  = longint'($signed(ax)) * longint'($signed(px));
        p1  = longint'($signed(ay)) * longint'($signed(py));
        p2  = longint'($signed(az)) * longint'($signed(pz));
        // three products can reach 3 * 2^62, so sum in a wider accumulator
        acc = 68'(p0);
        acc = acc + 68'(p1);
        acc = acc + 68'(p2);
        r   = longint'(acc >>> 16) - longint'($signed(off));
        if (r > SAT_MAX)
            return 32'h7FFF_FFFF;
        if (r < SAT_MIN)
            return 32'h8000_0000;
        return r[31:0];
    endfunction

    // ------------------------------------------------------------------------
    // batch predictor: classify one request, advance the bookkeeping and
    // return the result the block owes for it
    // ------------------------------------------------------------------------
    function automatic batch_res_t predict_batch(input vtx_req_t req);
        batch_res_t  res;
        logic        opens_poly;
        int unsigned n;
        res        = '0;
        opens_poly = 1'b0;
        n          = 32'(req.points);

        if (req.command) begin
            // start-batch wipes everything, an open polygon is abandoned
            batch_vtx_total  = 0;
            batch_poly_total = 0;
            poly_pts_left    = 0;
            poly_mode        = MODE_BETWEEN;
            poly_first_slot  = 0;
            write_slot       = 0;
            res.status       = ST_STARTED;
        end else if (poly_mode == MODE_FULL) begin
            res.status = ST_REJECTED;
        end else if (poly_mode == MODE_SKIPPING) begin
            res.status = ST_SKIPPED;
            if (poly_pts_left > 0)
                poly_pts_left--;
            if (poly_pts_left == 0)
                poly_mode = MODE_BETWEEN;
        end else if (poly_mode == MODE_STORING) begin
            // continuing vertex, its point count is ignored
            res.status = ST_STORED;
        end else if (n == 0) begin
            // empty polygon: reported as skipped, nothing else moves
            res.status = ST_SKIPPED;
        end else if (n > VCAP) begin
            // oversize polygon: this and the next n-1 vertices are skipped
            res.status    = ST_SKIPPED;
            poly_pts_left = n - 1;
            poly_mode     = (poly_pts_left != 0) ? MODE_SKIPPING : MODE_BETWEEN;
        end else if (batch_poly_total >= MAX_POLYS || n > VCAP - batch_vtx_total) begin
            // does not fit: batch closes until the next start-batch
            res.status    = ST_REJECTED;
            poly_pts_left = 0;
            poly_mode     = MODE_FULL;
        end else begin
            // new polygon reserves all of its slots at once
            res.status      = ST_STORED;
            opens_poly      = 1'b1;
            poly_first_slot = batch_vtx_total;
            write_slot      = batch_vtx_total;
            batch_vtx_total += n;
            batch_poly_total++;
            poly_pts_left   = n;
            poly_mode       = MODE_STORING;
        end

        if (res.status == ST_STORED) begin
            res.vertex_index      = 12'(write_slot);
            res.poly_index        = 11'(batch_poly_total - 1);
            res.poly_first_vertex = 12'(poly_first_slot);
            res.poly_count_out    = 13'(batch_vtx_total - poly_first_slot);
            res.first_of_poly     = opens_poly;
            res.tex_u = planar_coord(map_regs[CFG_U_AXIS_X[2:0]],
                                     map_regs[CFG_U_AXIS_Y[2:0]],
                                     map_regs[CFG_U_AXIS_Z[2:0]],
                                     map_regs[CFG_U_OFFSET[2:0]],
                                     req.x, req.y, req.z);
            res.tex_v = planar_coord(map_regs[CFG_V_AXIS_X[2:0]],
                                     map_regs[CFG_V_AXIS_Y[2:0]],
                                     map_regs[CFG_V_AXIS_Z[2:0]],
                                     map_regs[CFG_V_OFFSET[2:0]],
                                     req.x, req.y, req.z);
            res.x     = req.x;
            res.y     = req.y;
            res.z     = req.z;
            write_slot++;
            poly_pts_left--;
            if (poly_pts_left == 0)
                poly_mode = MODE_BETWEEN;
        end
        res.total_vertices = 13'(batch_vtx_total);
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinates: full-range noise, small values, extremes, mid-range
    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        if (r < 70)
            return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000 << 4;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset watchdog
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the run hangs on a handshake
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[vertex_batcher_planar_texgen_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random pop stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                hold = rx_idle_en ? pick_gap() : 0;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // outputs are stable mid-cycle, so the pop at the next edge is decided here
    always @(negedge clk) begin
        batch_res_t want;
        if (rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result popped with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("vertex_index", 32'(want.vertex_index), 32'(vertex_index));
                check_field("poly_index", 32'(want.poly_index), 32'(poly_index));
                check_field("poly_first_vertex", 32'(want.poly_first_vertex),
                            32'(poly_first_vertex));
                check_field("poly_count_out", 32'(want.poly_count_out),
                            32'(poly_count_out));
                check_field("first_of_poly", 32'(want.first_of_poly),
                            32'(first_of_poly));
                check_field("tex_u",             want.tex_u,             tex_u);
                check_field("tex_v",             want.tex_v,             tex_v);
                check_field("out_x",             want.x,                 out_x);
                check_field("out_y",             want.y,                 out_y);
                check_field("out_z",             want.z,                 out_z);
                check_field("total_vertices", 32'(want.total_vertices),
                            32'(total_vertices));
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side helpers, all entered and left right after a rising edge
    // ------------------------------------------------------------------------

    // push stays high on exit so back-to-back requests need no re-raise
    task automatic send_item(input vtx_req_t req);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        command     <= req.command;
        poly_points <= req.points;
        pos_x       <= req.x;
        pos_y       <= req.y;
        pos_z       <= req.z;
        do
            @(negedge clk);
        while (full);
        @(posedge clk);
        pending_results.push_back(predict_batch(req));
    endtask

    task automatic send_vertex(input logic [15:0] n, input logic [31:0] x, y, z);
        vtx_req_t req;
        req = '{command: 1'b0, points: n, x: x, y: y, z: z};
        send_item(req);
    endtask

    task automatic send_start();
        vtx_req_t req;
        req = '{command: 1'b1, points: 16'($urandom), x: $urandom, y: $urandom,
                z: $urandom};
        send_item(req);
    endtask

    // stop offering and wait until every owed result has been popped
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid is left high so consecutive writes need no re-raise
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        if (idx <= CFG_V_OFFSET)
            map_regs[idx[2:0]] = val;
    endtask

    // full reload of the mapping while the block is idle
    task automatic load_mapping(input logic [31:0] ux, uy, uz, vx, vy, vz, uo, vo);
        wait_idle();
        write_reg(CFG_U_AXIS_X, ux);
        write_reg(CFG_U_AXIS_Y, uy);
        write_reg(CFG_U_AXIS_Z, uz);
        write_reg(CFG_V_AXIS_X, vx);
        write_reg(CFG_V_AXIS_Y, vy);
        write_reg(CFG_V_AXIS_Z, vz);
        write_reg(CFG_U_OFFSET, uo);
        write_reg(CFG_V_OFFSET, vo);
        // out-of-range index must not disturb anything
        write_reg(CFG_UNMAPPED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset mapping first, then unit axes: triangle, empty polygon, single
    // point, a continuing vertex whose point count must be ignored
    task automatic test_basic_polygons();
        send_start();
        send_vertex(16'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_vertex(16'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(16'd3, 32'h0001_8000, 32'hFFFE_4000, 32'h0000_0001);
        load_mapping(ONE_Q16, 32'h0, 32'h0, 32'h0, ONE_Q16, 32'h0,
                     32'h0000_8000, 32'hFFFF_8000);
        send_vertex(16'd0, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        send_vertex(16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(16'd2, 32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_5678);
        send_vertex(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    endtask

    // polygons above the cap are skipped vertex by vertex, start abandons
    task automatic test_oversize();
        send_vertex(16'(VCAP + 1), rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd5, rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd1, rand_coord(), rand_coord(), rand_coord());
        send_start();
        send_vertex(16'hFFFF, rand_coord(), rand_coord(), rand_coord());
        send_start();
    endtask

    // too few free slots closes the batch; a cap-sized polygon fits alone
    task automatic test_batch_full();
        send_vertex(16'd1, rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'(VCAP), rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd1, rand_coord(), rand_coord(), rand_coord());
        send_start();
        send_vertex(16'(VCAP), rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd7, rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd7, rand_coord(), rand_coord(), rand_coord());
        send_start();
    endtask

    // fill the polygon table with single-point polygons, the next one bounces
    task automatic test_table_full();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_start();
        repeat (MAX_POLYS)
            send_vertex(16'd1, rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd1, rand_coord(), rand_coord(), rand_coord());
        send_vertex(16'd2, rand_coord(), rand_coord(), rand_coord());
        send_start();
        wait_idle();
    endtask

    // receiver holds off while the sender keeps pushing, so full must rise
    task automatic test_backpressure();
        int n;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        rx_hold_cycles = 250;
        send_start();
        repeat (12) begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_vertex(16'(n), rand_coord(), rand_coord(), rand_coord());
        end
        wait_idle();
    endtask

    // random stream, mostly well-formed polygons, some abandoned, oversize,
    // overflowing and plain noise requests
    task automatic run_random(input int n_items);
        vtx_req_t req;
        int       r;
        int       sent;
        sent = 0;
        while (sent < n_items) begin
            r           = $urandom_range(0, 99);
            req.command = 1'b0;
            req.points  = cur_poly_n;
            req.x       = rand_coord();
            req.y       = rand_coord();
            req.z       = rand_coord();
            case (poly_mode)
                MODE_STORING: begin
                    // big polygons are mostly cut short by a start-batch
                    if ((poly_pts_left > 64 && r < 20) || r < 3)
                        req.command = 1'b1;
                    else if (r < 33)
                        req.points = 16'($urandom);
                end
                MODE_SKIPPING, MODE_FULL: begin
                    if (r < 30)
                        req.command = 1'b1;
                    else
                        req.points = 16'($urandom);
                end
                default: begin
                    if (r < 55)
                        req.points = 16'($urandom_range(1, 8));
                    else if (r < 65)
                        req.points = 16'($urandom_range(9, 64));
                    else if (r < 70)
                        req.points = 16'($urandom_range(100, VCAP));
                    else if (r < 75 && batch_vtx_total > 0)
                        req.points = 16'($urandom_range(VCAP - batch_vtx_total + 1, VCAP));
                    else if (r < 80)
                        req.points = 16'($urandom_range(VCAP + 1, 65535));
                    else if (r < 83)
                        req.points = 16'd0;
                    else if (r < 88)
                        req.command = 1'b1;
                    else begin
                        req.command = ($urandom_range(0, 9) == 0);
                        req.points  = 16'($urandom);
                    end
                    cur_poly_n = req.points;
                end
            endcase
            // now and then the sender pauses until the block has drained
            if ($urandom_range(0, 199) == 0)
                wait_idle();
            send_item(req);
            sent++;
        end
    endtask

    // several mappings, extremes among them, each with its own idling mix
    task automatic test_random_phases();
        logic [31:0] a;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_mapping(ONE_Q16, 32'h0000_4000, 32'hFFFF_0000, 32'h0, ONE_Q16,
                                32'h0002_0000, 32'h0, 32'h0);
                // saturates high on most positive products
                1: load_mapping(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000);
                2: load_mapping(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF);
                3: load_mapping($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
                default: begin
                    a = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
                    load_mapping(a, ~a, 32'($urandom_range(0, 32'h0004_0000)),
                                 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000,
                                 a >>> 1, 32'h0, $urandom, $urandom);
                end
            endcase
            // first phase runs flat out on both sides
            tx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
            run_random(30);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n       <= 1'b0;
        push        <= 1'b0;
        command     <= 1'b0;
        poly_points <= '0;
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_polygons();
        test_oversize();
        test_batch_full();
        wait_idle();
        test_table_full();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[vertex_batcher_planar_texgen_core] OK");
        else
            $display("[vertex_batcher_planar_texgen_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
